### rtl/core/tcc_pkg.sv
package tcc_pkg;

	localparam int unsigned ID_W     = 11;
	localparam int unsigned CIDX_W   = 10;
	localparam int unsigned CNODE_W  = 10;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned KIND_W   = 2;

	localparam logic [ID_W-1:0] NULL_ID = 11'd1024;

	localparam logic [KIND_W-1:0] KIND_LOAD     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLASSIFY = 2'd1;
	localparam logic [KIND_W-1:0] KIND_LOOKUP   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_SELF  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_WALK  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              restart_load;
		logic [ID_W-1:0]   parent_id;
		logic [ID_W-1:0]   node_id;
		logic [CIDX_W-1:0] child_index;
	} req_item_t;

	typedef struct packed {
		logic [ID_W-1:0]     child;
		logic [CNODE_W-1:0]  child_node;
		logic [ID_W-1:0]     child_count;
		logic [STATUS_W-1:0] status;
	} rsp_item_t;

endpackage

### rtl/core/tcc_if.sv
interface tcc_req_if import tcc_pkg::*;;
	logic      valid;
	logic      ready;
	req_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tcc_rsp_if import tcc_pkg::*;;
	logic      valid;
	logic      ready;
	rsp_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/tcc_ram.sv
module tcc_ram #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/tree_child_classifier_top.sv
// Channel   Dir  Handshake     Payload
// req       in   valid/ready   kind, restart_load, parent_id, node_id, child_index
// rsp       out  valid/ready   child, child_node, child_count, status
// cfg       in   cfg_we        cfg_wdata = parent_node
//
// One item at a time; every item gives one result item.
// Load goes straight to the finish state; lookup first does one child-table read. Classify
// finishes at once when the start node settles it, otherwise it walks up node by node and
// ends on a table read (child found, self parent) or on a check (null, unloaded, walk limit).
// Each level is a check state plus a registered node-table read.
// Reset clears the counters and control only; both tables are plain RAM, no clear pass.
// A finished result holds in the output register; a stalled rsp channel holds the
// next result in the finish state and keeps req.ready low until the register frees.
module tree_child_classifier_top import tcc_pkg::*; #(
	parameter int unsigned MAX_NODES = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [9:0]   cfg_wdata,
	tcc_req_if.sink      req,
	tcc_rsp_if.source    rsp
);

	// node index width, count width (holds MAX_NODES), and a compare width
	localparam int unsigned NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int unsigned CW = $clog2(MAX_NODES + 1);
	localparam int unsigned WW = (CW > ID_W) ? CW : ID_W;
	// node entry: parent pointer, child flag, child slot
	localparam int unsigned EW = ID_W + 1 + NW;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOOK = 3'd1;
	localparam logic [2:0] S_WCHK = 3'd2;
	localparam logic [2:0] S_WRD  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0]          state_q;
	logic [9:0]          parent_node_q;
	logic [CW-1:0]       nodes_q;
	logic [CW-1:0]       kids_q;
	logic [ID_W-1:0]     cur_q;
	logic [CW-1:0]       visits_q;
	logic [ID_W-1:0]     res_child_q;
	logic [CNODE_W-1:0]  res_cnode_q;
	logic [STATUS_W-1:0] res_status_q;
	logic                out_valid_q;
	rsp_item_t           out_q;

	logic          req_fire;
	logic [CW-1:0] nl_eff;
	logic [CW-1:0] cf_eff;
	logic          load_ok;
	logic          is_kid;
	logic [ID_W-1:0] outside;
	logic [WW-1:0] nl_w;
	logic [WW-1:0] cur_w;
	logic          walk_go;
	logic          cidx_ok;
	logic          fin_go;

	logic [ID_W-1:0]     start_child;
	logic [STATUS_W-1:0] start_status;
	logic [2:0]          start_state;

	logic          node_we;
	logic [EW-1:0] node_wdata;
	logic          node_re;
	logic [EW-1:0] node_rdata;
	logic          kid_we;
	logic          kid_re;
	logic [NW-1:0] kid_rdata;

	logic [ID_W-1:0] ent_parent;
	logic            ent_kid;
	logic [NW-1:0]   ent_slot;

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	always_comb begin
		req_fire = req.valid & req.ready;
		// a restarting load sees empty counters
		nl_eff   = req.data.restart_load ? '0 : nodes_q;
		cf_eff   = req.data.restart_load ? '0 : kids_q;
		load_ok  = (nl_eff != CW'(MAX_NODES)) && (req.data.parent_id <= NULL_ID);
		is_kid   = (req.data.parent_id == {1'b0, parent_node_q});
		outside  = ID_W'(kids_q) + 11'd1;
		nl_w     = WW'(nodes_q);
		cur_w    = WW'(cur_q);
		cidx_ok  = WW'(req.data.child_index) < WW'(kids_q);
		walk_go  = (cur_q != NULL_ID) && (cur_w < nl_w) && (WW'(visits_q) < nl_w);
		// the output register is free or being emptied this cycle
		fin_go   = (state_q == S_FIN) && (!out_valid_q || rsp.ready);

		node_we    = req_fire && (req.data.kind == KIND_LOAD) && load_ok;
		node_wdata = {req.data.parent_id, is_kid, NW'(cf_eff)};
		kid_we     = node_we && is_kid;
		kid_re     = req_fire && (req.data.kind == KIND_LOOKUP) && cidx_ok;
		node_re    = (state_q == S_WCHK) && walk_go;

		ent_parent = node_rdata[EW-1 -: ID_W];
		ent_kid    = node_rdata[NW];
		ent_slot   = node_rdata[NW-1:0];
	end

	// first decision on an accepted item: a result right away or a further state
	always_comb begin
		start_child  = '0;
		start_status = ST_OK;
		start_state  = S_FIN;
		case (req.data.kind)
			KIND_LOAD: begin
				if (!load_ok) begin
					start_status = ST_RANGE;
				end
			end
			KIND_CLASSIFY: begin
				if (req.data.node_id == NULL_ID) begin
					start_child = outside;
				end else if (req.data.node_id > NULL_ID ||
						WW'(req.data.node_id) >= nl_w) begin
					start_child  = outside;
					start_status = ST_RANGE;
				end else if (req.data.node_id == {1'b0, parent_node_q}) begin
					start_child = ID_W'(kids_q);
				end else begin
					start_state = S_WCHK;
				end
			end
			KIND_LOOKUP: begin
				if (cidx_ok) begin
					start_state = S_LOOK;
				end else begin
					start_status = ST_RANGE;
				end
			end
			default: begin
				start_status = ST_RANGE;
			end
		endcase
	end

	tcc_ram #(.DEPTH(MAX_NODES), .WIDTH(EW)) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (NW'(nl_eff)),
		.wdata (node_wdata),
		.re    (node_re),
		.raddr (NW'(cur_q)),
		.rdata (node_rdata)
	);

	tcc_ram #(.DEPTH(MAX_NODES), .WIDTH(NW)) u_kid_ram (
		.clk   (clk),
		.we    (kid_we),
		.waddr (NW'(cf_eff)),
		.wdata (NW'(nl_eff)),
		.re    (kid_re),
		.raddr (NW'(req.data.child_index)),
		.rdata (kid_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			parent_node_q <= '0;
			nodes_q       <= '0;
			kids_q        <= '0;
			cur_q         <= '0;
			visits_q      <= '0;
			res_child_q   <= '0;
			res_cnode_q   <= '0;
			res_status_q  <= ST_OK;
			out_valid_q   <= 1'b0;
			out_q         <= '0;
		end else begin
			if (cfg_we) begin
				parent_node_q <= cfg_wdata;
			end
			// load the output item from the finish state, else drop it once taken
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						res_child_q  <= start_child;
						res_cnode_q  <= '0;
						res_status_q <= start_status;
						state_q      <= start_state;
						cur_q        <= req.data.node_id;
						visits_q     <= '0;
						if (req.data.kind == KIND_LOAD) begin
							// counters restart even when the load itself is rejected
							nodes_q <= nl_eff + CW'(load_ok);
							kids_q  <= cf_eff + CW'(load_ok && is_kid);
						end
					end
				end
				S_LOOK: begin
					res_cnode_q <= CNODE_W'(kid_rdata);
					state_q     <= S_FIN;
				end
				S_WCHK: begin
					// check the current node, then read its entry
					if (walk_go) begin
						visits_q <= visits_q + 1'b1;
						state_q  <= S_WRD;
					end else begin
						res_child_q <= outside;
						state_q     <= S_FIN;
						if (cur_q == NULL_ID) begin
							res_status_q <= ST_OK;
						end else if (cur_w >= nl_w) begin
							res_status_q <= ST_RANGE;
						end else begin
							res_status_q <= ST_WALK;
						end
					end
				end
				S_WRD: begin
					if (ent_kid) begin
						res_child_q <= ID_W'(ent_slot);
						state_q     <= S_FIN;
					end else if (ent_parent == cur_q) begin
						res_child_q  <= outside;
						res_status_q <= ST_SELF;
						state_q      <= S_FIN;
					end else begin
						cur_q   <= ent_parent;
						state_q <= S_WCHK;
					end
				end
				S_FIN: begin
					// hold until the output register is free
					if (fin_go) begin
						out_q.child       <= res_child_q;
						out_q.child_node  <= res_cnode_q;
						out_q.child_count <= ID_W'(kids_q);
						out_q.status      <= res_status_q;
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### dv/tb_tree_child_classifier_top.sv
module tb_tree_child_classifier_top import tcc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NODE_CAP     = 1024;
	localparam int unsigned CLK_PERIOD   = 8;
	localparam int unsigned CYCLE_LIMIT  = 1_000_000;
	// items after the directed part, the table fill included
	localparam int unsigned RANDOM_ITEMS = 1120;
	localparam int unsigned QUIET_TAIL   = 150;
	localparam int unsigned LONG_HOLD    = 400;
	// longest legal walk in the random phases is under a hundred levels
	localparam int unsigned SETTLE       = 200;
	localparam int unsigned REPORT_MAX   = 10;
	localparam int          FILL_PHASE   = 2;
	localparam int          HOLD_PHASE   = 1;
	// the one kind code the block does not define
	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

	// Shadow copy of the node tree. It tracks the parent links, the child slots and the
	// count registers item by item and queues the result that each accepted item owes.
	class tree_shadow;
		int unsigned up_link[NODE_CAP];
		int unsigned slot_of[NODE_CAP];
		int unsigned node_at_slot[NODE_CAP];
		int unsigned loaded_cnt;
		int unsigned child_cnt;
		int unsigned anchor;
		int unsigned accepted;
		int unsigned faults;
		rsp_item_t   answers_due[$];

		// Climb parent links from start until a child of the anchor node is met or the walk ends.
		function void walk_up(input int unsigned start, output int unsigned verdict,
				output logic [STATUS_W-1:0] st);
			int unsigned cur;
			int unsigned visits;
			verdict = child_cnt + 1;
			st = ST_OK;
			cur = start;
			visits = 0;
			if (start == NULL_ID)
				return;
			if (start > NULL_ID || start >= loaded_cnt) begin
				st = ST_RANGE;
				return;
			end
			if (start == anchor) begin
				verdict = child_cnt;
				return;
			end
			forever begin
				if (cur == NULL_ID)
					return;
				if (cur >= loaded_cnt) begin
					st = ST_RANGE;
					return;
				end
				visits++;
				if (visits > loaded_cnt) begin
					st = ST_WALK;
					return;
				end
				if (slot_of[cur] < NODE_CAP) begin
					verdict = slot_of[cur];
					return;
				end
				if (up_link[cur] == cur) begin
					st = ST_SELF;
					return;
				end
				cur = up_link[cur];
			end
		endfunction

		function rsp_item_t resolve(req_item_t it);
			rsp_item_t           r;
			int unsigned         pid;
			int unsigned         verdict;
			logic [STATUS_W-1:0] st;
			r = '0;
			st = ST_OK;
			pid = it.parent_id;
			case (it.kind)
			KIND_LOAD: begin
				if (it.restart_load) begin
					loaded_cnt = 0;
					child_cnt = 0;
				end
				if (loaded_cnt >= NODE_CAP || pid > NULL_ID) begin
					st = ST_RANGE;
				end else begin
					up_link[loaded_cnt] = pid;
					if (pid == anchor) begin
						slot_of[loaded_cnt] = child_cnt;
						node_at_slot[child_cnt] = loaded_cnt;
						child_cnt++;
					end else begin
						slot_of[loaded_cnt] = NODE_CAP;
					end
					loaded_cnt++;
				end
			end
			KIND_CLASSIFY: begin
				walk_up(it.node_id, verdict, st);
				r.child = ID_W'(verdict);
			end
			KIND_LOOKUP: begin
				if (it.child_index < child_cnt)
					r.child_node = CNODE_W'(node_at_slot[it.child_index]);
				else
					st = ST_RANGE;
			end
			default: st = ST_RANGE;
			endcase
			r.child_count = ID_W'(child_cnt);
			r.status = st;
			return r;
		endfunction

		function void note_accept(req_item_t it);
			answers_due.insert(answers_due.size(), resolve(it));
			accepted++;
		endfunction

		function void check_answer(rsp_item_t got);
			rsp_item_t want;
			if (answers_due.size() == 0) begin
				faults++;
				if (faults <= REPORT_MAX)
					$display("%0t: result with none outstanding: %s%0d %s%0d %s%0d %s%0d",
						$time, "child=", got.child, "node=", got.child_node,
						"count=", got.child_count, "st=", got.status);
				return;
			end
			want = answers_due.pop_front();
			if (got.child !== want.child || got.child_node !== want.child_node ||
					got.child_count !== want.child_count || got.status !== want.status) begin
				faults++;
				if (faults <= REPORT_MAX)
					$display("%0t: mismatch exp child=%0d node=%0d count=%0d st=%0d, %s",
						$time, want.child, want.child_node, want.child_count, want.status,
						$sformatf("got child=%0d node=%0d count=%0d st=%0d",
						got.child, got.child_node, got.child_count, got.status));
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [9:0]  cfg_wdata = '0;
	int unsigned cycle_cnt = 0;
	int unsigned src_gap_pct = 0;
	int unsigned sink_gap_pct = 0;
	bit          quiet_tail = 1'b0;
	bit          hold_rsp = 1'b0;
	tree_shadow  sb = new;

	tcc_req_if req_ch();
	tcc_rsp_if rsp_ch();

	tree_child_classifier_top #(.MAX_NODES(NODE_CAP)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Hard stop: a hung handshake or a lost result ends here.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("tb_tree_child_classifier_top: FAIL");
			$finish;
		end
	end

	// Observe both channels at the rising edge; drivers only move on the falling edge,
	// so the values seen here are the ones the block sampled.
	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready)
			sb.note_accept(req_ch.data);
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_answer(rsp_ch.data);
	end

	// Result sink. Stall in short random bursts, and once hold off for a long stretch
	// while the sender keeps offering, so the block backs up and drops req.ready.
	initial begin : rsp_sink
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_rsp) begin
				hold_rsp = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else if (!quiet_tail && $urandom_range(0, 99) < sink_gap_pct) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
		end
	end

	// Write the anchor node register. Call only while nothing is in flight.
	task automatic write_anchor(input logic [9:0] v);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.anchor = v;
	endtask

	// Offer one item and hold it until the block takes it. Fields the kind ignores
	// carry random bits. Enter and leave just after a falling edge.
	task automatic push(input logic [KIND_W-1:0] kind, input logic restart,
			input logic [ID_W-1:0] arg);
		req_item_t it;
		it.kind = kind;
		it.restart_load = (kind == KIND_LOAD) ? restart : 1'($urandom_range(0, 1));
		it.parent_id = ID_W'($urandom_range(0, 2047));
		it.node_id = ID_W'($urandom_range(0, 2047));
		it.child_index = CIDX_W'($urandom_range(0, 1023));
		case (kind)
		KIND_LOAD: it.parent_id = arg;
		KIND_CLASSIFY: it.node_id = arg;
		KIND_LOOKUP: it.child_index = arg[CIDX_W-1:0];
		default: ;
		endcase
		if (!quiet_tail && $urandom_range(0, 99) < src_gap_pct) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= it;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Stop offering and wait until every owed result has come back.
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (sb.answers_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Parent for node n: mostly well-formed links (the anchor, an earlier node, no parent),
	// with some self links, forward links that may close loops, and out-of-range ids.
	function automatic logic [ID_W-1:0] pick_parent(input int unsigned n);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return ID_W'(sb.anchor);
		if (r < 62)
			return (n == 0) ? NULL_ID : ID_W'($urandom_range(0, n - 1));
		if (r < 72)
			return NULL_ID;
		if (r < 77)
			return ID_W'(n);
		if (r < 84)
			return ID_W'(n + $urandom_range(1, 4));
		if (r < 89)
			return ID_W'($urandom_range(1025, 2047));
		return ID_W'($urandom_range(0, 1023));
	endfunction

	initial begin : stimulus
		int unsigned nload;
		int unsigned nquery;
		int unsigned pick;
		int unsigned base;
		int unsigned done_cnt;
		logic [ID_W-1:0] arg;
		logic [9:0]  anchor_v;
		int          phase;

		req_ch.valid = 1'b0;
		req_ch.data = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed tree with anchor node 2:
		//   0 root, 1 -> 0, 2 -> 1, 3 -> 2 (child 0), 4 -> 3, 5 -> 2 (child 1),
		//   6 -> itself, 7 -> 8, 8 and 9 point at each other, 10 -> unloaded 15.
		write_anchor(10'd2);
		push(KIND_LOAD, 1'b1, NULL_ID);
		push(KIND_LOAD, 1'b0, 11'd0);
		push(KIND_LOAD, 1'b0, 11'd1);
		push(KIND_LOAD, 1'b0, 11'd2);
		push(KIND_LOAD, 1'b0, 11'd3);
		push(KIND_LOAD, 1'b0, 11'd2);
		push(KIND_LOAD, 1'b0, 11'd6);
		push(KIND_LOAD, 1'b0, 11'd8);
		push(KIND_LOAD, 1'b0, 11'd9);
		push(KIND_LOAD, 1'b0, 11'd8);
		push(KIND_LOAD, 1'b0, 11'd15);
		// bad parent ids: nothing stored
		push(KIND_LOAD, 1'b0, 11'd1025);
		push(KIND_LOAD, 1'b0, 11'd2047);
		push(KIND_CLASSIFY, 1'b0, 11'd4);     // under child 0
		push(KIND_CLASSIFY, 1'b0, 11'd5);     // child 1 itself
		push(KIND_CLASSIFY, 1'b0, 11'd2);     // the anchor
		push(KIND_CLASSIFY, 1'b0, 11'd1);     // climbs out past the root
		push(KIND_CLASSIFY, 1'b0, NULL_ID);   // null start
		push(KIND_CLASSIFY, 1'b0, 11'd2047);  // id out of range
		push(KIND_CLASSIFY, 1'b0, 11'd11);    // not loaded yet
		push(KIND_CLASSIFY, 1'b0, 11'd6);     // self parent
		push(KIND_CLASSIFY, 1'b0, 11'd7);     // loop: walk limit
		push(KIND_CLASSIFY, 1'b0, 11'd10);    // walk hits an unloaded node
		push(KIND_LOOKUP, 1'b0, 11'd0);
		push(KIND_LOOKUP, 1'b0, 11'd1);
		push(KIND_LOOKUP, 1'b0, 11'd2);       // past the child count
		push(KIND_SPARE, 1'b0, 11'd0);

		// Random phases. Each one starts from an idle block: the sender pauses until every
		// owed result is back, then the anchor is rewritten and a fresh tree is loaded.
		// The table fill runs without idling, and so do the phases that start within the quiet tail.
		base = sb.accepted;
		phase = 0;
		done_cnt = 0;
		while (done_cnt < RANDOM_ITEMS) begin
			drain();
			phase++;
			quiet_tail = (phase == FILL_PHASE) || (RANDOM_ITEMS - done_cnt < QUIET_TAIL);
			case ($urandom_range(0, 3))
			0: src_gap_pct = 0;
			1: src_gap_pct = 10;
			2: src_gap_pct = 25;
			default: src_gap_pct = 50;
			endcase
			case ($urandom_range(0, 3))
			0: sink_gap_pct = 0;
			1: sink_gap_pct = 10;
			2: sink_gap_pct = 25;
			default: sink_gap_pct = 50;
			endcase

			if (phase == FILL_PHASE) begin
				// Fill the whole table with children of the top node id, then overflow it.
				// This drives the child count and the classify result to their top values.
				write_anchor(10'd1023);
				push(KIND_LOAD, 1'b1, 11'd1023);
				repeat (NODE_CAP) push(KIND_LOAD, 1'b0, 11'd1023);
				push(KIND_LOOKUP, 1'b0, 11'd1023);
				push(KIND_CLASSIFY, 1'b0, 11'd1023);
				push(KIND_CLASSIFY, 1'b0, NULL_ID);
				repeat (12) begin
					push($urandom_range(0, 1) ? KIND_CLASSIFY : KIND_LOOKUP, 1'b0,
						ID_W'($urandom_range(0, 1024)));
				end
			end else begin
				case ($urandom_range(0, 9))
				0: anchor_v = 10'd0;
				1: anchor_v = 10'd1023;
				2: anchor_v = 10'($urandom_range(0, 1023));
				default: anchor_v = 10'($urandom_range(0, 12));
				endcase
				write_anchor(anchor_v);
				if (phase == HOLD_PHASE)
					hold_rsp = 1'b1;

				nload = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) :
					$urandom_range(1, 20);
				push(KIND_LOAD, 1'b1, pick_parent(0));
				repeat (nload - 1) push(KIND_LOAD, 1'b0, pick_parent(sb.loaded_cnt));

				// Mostly queries against the loaded tree, some appended nodes and noise.
				nquery = $urandom_range(4, 24);
				repeat (nquery) begin
					pick = $urandom_range(0, 99);
					if (pick < 50) begin
						case ($urandom_range(0, 9))
						0: arg = NULL_ID;
						1: arg = ID_W'(sb.anchor);
						2: arg = ID_W'($urandom_range(0, 2047));
						3: arg = ID_W'(sb.loaded_cnt);
						default: arg = (sb.loaded_cnt == 0) ? '0 :
							ID_W'($urandom_range(0, sb.loaded_cnt - 1));
						endcase
						push(KIND_CLASSIFY, 1'b0, arg);
					end else if (pick < 72) begin
						if ($urandom_range(0, 9) < 7)
							arg = ID_W'((sb.child_cnt > 1023) ? 1023 :
								$urandom_range(0, sb.child_cnt));
						else
							arg = ID_W'($urandom_range(0, 1023));
						push(KIND_LOOKUP, 1'b0, arg);
					end else if (pick < 88) begin
						push(KIND_LOAD, 1'b0, pick_parent(sb.loaded_cnt));
					end else if (pick < 93) begin
						push(KIND_LOAD, 1'b1, pick_parent(0));
					end else begin
						push(KIND_SPARE, 1'b0, '0);
					end
				end
			end
			done_cnt = sb.accepted - base;
		end

		// Let the last results come home, then give stragglers time to show up.
		quiet_tail = 1'b1;
		drain();
		repeat (SETTLE) @(negedge clk);
		sb.faults += sb.answers_due.size();
		if (sb.faults == 0) begin
			$display("tb_tree_child_classifier_top: PASS");
		end else begin
			$display("tb_tree_child_classifier_top: FAIL");
		end
		$finish;
	end

endmodule
